// ===== src/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    localparam int DEF_MAX_DEPTH = 16;
    localparam int DEF_DATA_BITS = 32;

    // Fixed field widths of the channels
    localparam int ACT_W = 2;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_READ = 2'd2,
        ST_RESP = 2'd3
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic cfg_wr;  // take new capacity, empty the deque
        logic load;    // capture the input item
        logic exec;    // apply the operation to pointers, count and ring
        logic read;    // read both ends into the result registers
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/cdq_if.sv =====
// ----------------------------------------------------------------------------
// cdq_if
// Valid/ready channel interfaces for operations, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_op_if;
    logic                              valid;
    logic                              ready;
    logic        [cdq_pkg::ACT_W-1:0]  action;
    logic signed [cdq_pkg::VAL_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface cdq_res_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic signed [cdq_pkg::VAL_W-1:0]  front_value;
    logic signed [cdq_pkg::VAL_W-1:0]  rear_value;
    logic                              is_empty;
    logic                              is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

interface cdq_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cdq_pkg::CAP_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accept, execute, read ends, hold result until transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_ready,
    input  wire logic          i_cfg_valid,
    output      logic          o_cfg_ready,
    output      logic          o_out_valid,
    input  wire logic          i_out_ready,
    output      cdq_pkg::t_cmd o_cmd
);

    cdq_pkg::t_state r_state;
    cdq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = cdq_pkg::ST_EXEC;
            end
            cdq_pkg::ST_EXEC: n_state = cdq_pkg::ST_READ;
            cdq_pkg::ST_READ: n_state = cdq_pkg::ST_RESP;
            cdq_pkg::ST_RESP: begin
                if (i_out_ready) n_state = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == cdq_pkg::ST_IDLE);
        o_cfg_ready   = (r_state == cdq_pkg::ST_IDLE);
        o_out_valid   = (r_state == cdq_pkg::ST_RESP);
        o_cmd.load    = (r_state == cdq_pkg::ST_IDLE) && i_in_valid;
        o_cmd.cfg_wr  = (r_state == cdq_pkg::ST_IDLE) && i_cfg_valid;
        o_cmd.exec    = (r_state == cdq_pkg::ST_EXEC);
        o_cmd.read    = (r_state == cdq_pkg::ST_READ);
    end

endmodule

`default_nettype wire

// ===== src/cdq_dpath.sv =====
// ----------------------------------------------------------------------------
// cdq_dpath
// Ring store, end pointers, item count, capacity and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_dpath #(
    parameter int MAX_DEPTH = cdq_pkg::DEF_MAX_DEPTH,
    parameter int DATA_BITS = cdq_pkg::DEF_DATA_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire cdq_pkg::t_cmd                       i_cmd,
    input  wire logic        [cdq_pkg::ACT_W-1:0]    i_action,
    input  wire logic signed [cdq_pkg::VAL_W-1:0]    i_value,
    input  wire logic        [cdq_pkg::CAP_W-1:0]    i_cfg_data,
    output      logic                                o_ok,
    output      logic signed [cdq_pkg::VAL_W-1:0]    o_front_value,
    output      logic signed [cdq_pkg::VAL_W-1:0]    o_rear_value,
    output      logic                                o_is_empty,
    output      logic                                o_is_full
);

    localparam int CAP_W  = cdq_pkg::CAP_W;
    localparam int PTR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW     = (PTR_W > CAP_W) ? PTR_W : CAP_W;
    localparam int CAP_MAX_I = (MAX_DEPTH > 31) ? 31 : MAX_DEPTH;
    localparam int CAP_RST_I = (MAX_DEPTH > 16) ? 16 : MAX_DEPTH;
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(CAP_MAX_I);
    localparam logic [CAP_W-1:0] CAP_RST   = CAP_W'(CAP_RST_I);

    // Slot pointers always stay below the capacity
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
        logic [CW-1:0] nx;
        nx = CW'(p) + CW'(1);
        return (nx == CW'(c)) ? '0 : nx[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
        logic [CW-1:0] lst;
        lst = CW'(c) - CW'(1);
        return (p == '0) ? lst[PTR_W-1:0] : p - PTR_W'(1);
    endfunction

    logic [DATA_BITS-1:0] r_mem [MAX_DEPTH];

    logic [CAP_W-1:0]      r_cap,   n_cap;
    logic [CAP_W-1:0]      r_count, n_count;
    logic [PTR_W-1:0]      r_front, n_front;
    logic [PTR_W-1:0]      r_rear,  n_rear;
    logic                  r_ok,    n_ok;
    cdq_pkg::t_action      r_action;
    logic [DATA_BITS-1:0]  r_value;
    logic [DATA_BITS-1:0]  r_rd_front;
    logic [DATA_BITS-1:0]  r_rd_rear;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [CAP_W-1:0]      cfg_eff;
    logic                  is_full;
    logic                  is_empty;
    logic [63:0]           in_ext;
    logic [63:0]           f_ext;
    logic [63:0]           r_ext;

    // Out-of-range capacity codes clamp into 1..min(MAX_DEPTH, 31)
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_eff = CAP_W'(1);
        end else if (i_cfg_data > CAP_LIMIT) begin
            cfg_eff = CAP_LIMIT;
        end else begin
            cfg_eff = i_cfg_data;
        end
    end

    assign is_full  = (r_count == r_cap);
    assign is_empty = (r_count == '0);

    always_comb begin
        n_cap   = r_cap;
        n_count = r_count;
        n_front = r_front;
        n_rear  = r_rear;
        n_ok    = r_ok;
        wr_en   = 1'b0;
        wr_addr = r_front;
        if (i_cmd.cfg_wr) begin
            n_cap   = cfg_eff;
            n_count = '0;
            n_front = PTR_W'(cfg_eff - CAP_W'(1));
            n_rear  = '0;
        end else if (i_cmd.exec) begin
            n_ok = 1'b0;
            case (r_action)
                cdq_pkg::ACT_PUSH_FRONT: begin
                    if (!is_full) begin
                        wr_en   = 1'b1;
                        wr_addr = r_front;
                        n_front = ptr_dec(r_front, r_cap);
                        n_count = r_count + CAP_W'(1);
                        n_ok    = 1'b1;
                    end
                end
                cdq_pkg::ACT_PUSH_REAR: begin
                    if (!is_full) begin
                        wr_en   = 1'b1;
                        wr_addr = r_rear;
                        n_rear  = ptr_inc(r_rear, r_cap);
                        n_count = r_count + CAP_W'(1);
                        n_ok    = 1'b1;
                    end
                end
                cdq_pkg::ACT_POP_FRONT: begin
                    if (!is_empty) begin
                        n_front = ptr_inc(r_front, r_cap);
                        n_count = r_count - CAP_W'(1);
                        n_ok    = 1'b1;
                    end
                end
                cdq_pkg::ACT_POP_REAR: begin
                    if (!is_empty) begin
                        n_rear  = ptr_dec(r_rear, r_cap);
                        n_count = r_count - CAP_W'(1);
                        n_ok    = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RST;
            r_count <= '0;
            r_front <= PTR_W'(CAP_RST - CAP_W'(1));
            r_rear  <= '0;
        end else begin
            r_cap   <= n_cap;
            r_count <= n_count;
            r_front <= n_front;
            r_rear  <= n_rear;
        end
    end

    assign in_ext = {32'b0, i_value};

    always_ff @(posedge i_clk) begin
        r_ok <= n_ok;
        if (i_cmd.load) begin
            r_action <= cdq_pkg::t_action'(i_action);
            r_value  <= in_ext[DATA_BITS-1:0];
        end
    end

    // Ring store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        if (i_cmd.read) begin
            r_rd_front <= r_mem[ptr_inc(r_front, r_cap)];
            r_rd_rear  <= r_mem[ptr_dec(r_rear, r_cap)];
        end
    end

    assign f_ext = 64'(r_rd_front);
    assign r_ext = 64'(r_rd_rear);

    assign o_ok          = r_ok;
    assign o_front_value = is_empty ? '0 : f_ext[cdq_pkg::VAL_W-1:0];
    assign o_rear_value  = is_empty ? '0 : r_ext[cdq_pkg::VAL_W-1:0];
    assign o_is_empty    = is_empty;
    assign o_is_full     = is_full;

endmodule

`default_nettype wire

// ===== src/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a ring store of configurable capacity.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                         transfer
//   i_in     in   action, value                                   valid & ready
//   o_out    out  ok, front_value, rear_value, is_empty, is_full  valid & ready
//   i_cfg    in   data (capacity)                                 valid & ready
//
// Result valid rises once the execute and registered ring read states have passed
// after the input transfer. On the result transfer the controller returns to idle,
// where it takes the next input: no new input is accepted before that transfer.
// A capacity write is registered at its transfer and empties the deque.
// Reset empties the deque with capacity 16; ring contents are not cleared.
// Input and config are stalled while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
    parameter int MAX_DEPTH = cdq_pkg::DEF_MAX_DEPTH,
    parameter int DATA_BITS = cdq_pkg::DEF_DATA_BITS
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    cdq_op_if.sink    i_in,
    cdq_res_if.source o_out,
    cdq_cfg_if.sink   i_cfg
);

    cdq_pkg::t_cmd cmd;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    cdq_dpath #(
        .MAX_DEPTH (MAX_DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_in.action),
        .i_value       (i_in.value),
        .i_cfg_data    (i_cfg.data),
        .o_ok          (o_out.ok),
        .o_front_value (o_out.front_value),
        .o_rear_value  (o_out.rear_value),
        .o_is_empty    (o_out.is_empty),
        .o_is_full     (o_out.is_full)
    );

endmodule

`default_nettype wire

// ===== tb/cdq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Watches the operation, result and capacity channels of the circular deque.
// Keeps its own copy of the ring, the slot pointers and the fill level, works
// out the status each accepted operation must return, and compares every
// result transfer field by field against the oldest outstanding status.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cdq_op_if         i_op,
    cdq_res_if        i_res,
    cdq_cfg_if        i_cfg,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results_seen,
    output int        o_refused_seen,
    output int        o_full_seen
);

    localparam int RING_DEPTH  = DEF_MAX_DEPTH;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] front_value;
        logic [VAL_W-1:0] rear_value;
        logic             is_empty;
        logic             is_full;
    } t_deque_status;

    logic [VAL_W-1:0] ring [RING_DEPTH];
    logic [CAP_W-1:0] capacity_reg;
    int unsigned      depth_used;
    int unsigned      front_pos;   // free slot just ahead of the front item
    int unsigned      rear_pos;    // free slot just past the rear item
    int unsigned      fill;

    t_deque_status    status_q [$];

    task automatic clear_deque();
        if (capacity_reg == '0) begin
            depth_used = 1;
        end else if (capacity_reg > RING_DEPTH) begin
            depth_used = RING_DEPTH;
        end else begin
            depth_used = capacity_reg;
        end
        front_pos = depth_used - 1;
        rear_pos  = 0;
        fill      = 0;
    endtask

    task automatic apply_deque_op(input t_action act, input logic [VAL_W-1:0] val,
                                  output t_deque_status s);
        s = '0;
        case (act)
            ACT_PUSH_FRONT: begin
                if (fill < depth_used) begin
                    ring[front_pos] = val;
                    front_pos = (front_pos + depth_used - 1) % depth_used;
                    fill++;
                    s.ok = 1'b1;
                end
            end
            ACT_PUSH_REAR: begin
                if (fill < depth_used) begin
                    ring[rear_pos] = val;
                    rear_pos = (rear_pos + 1) % depth_used;
                    fill++;
                    s.ok = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (fill != 0) begin
                    front_pos = (front_pos + 1) % depth_used;
                    fill--;
                    s.ok = 1'b1;
                end
            end
            ACT_POP_REAR: begin
                if (fill != 0) begin
                    rear_pos = (rear_pos + depth_used - 1) % depth_used;
                    fill--;
                    s.ok = 1'b1;
                end
            end
        endcase
        // ends read back as zero once the deque is empty
        if (fill != 0) begin
            s.front_value = ring[(front_pos + 1) % depth_used];
            s.rear_value  = ring[(rear_pos + depth_used - 1) % depth_used];
        end
        s.is_empty = (fill == 0);
        s.is_full  = (fill == depth_used);
    endtask

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] want,
                                   input logic [VAL_W-1:0] got);
        $display("[%0t] MISMATCH result %0d %s: expected %h, got %h",
                 $realtime, o_results_seen, what, want, got);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
        o_refused_seen = 0;
        o_full_seen    = 0;
        foreach (ring[k]) ring[k] = '0;
        capacity_reg = CAP_RESET;
        clear_deque();
    end

    always @(posedge i_clk) begin
        t_deque_status want;
        t_deque_status predicted;
        if (!i_rst_n) begin
            capacity_reg = CAP_RESET;
            clear_deque();
            status_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                capacity_reg = i_cfg.data;
                clear_deque();
            end
            if (i_op.valid && i_op.ready) begin
                apply_deque_op(t_action'(i_op.action), i_op.value, predicted);
                status_q.push_back(predicted);
            end
            if (i_res.valid && i_res.ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch("arrived with nothing outstanding", '0, '0);
                end else begin
                    want = status_q.pop_front();
                    if (i_res.ok !== want.ok)
                        report_mismatch("ok", want.ok, i_res.ok);
                    if (i_res.front_value !== want.front_value)
                        report_mismatch("front_value", want.front_value, i_res.front_value);
                    if (i_res.rear_value !== want.rear_value)
                        report_mismatch("rear_value", want.rear_value, i_res.rear_value);
                    if (i_res.is_empty !== want.is_empty)
                        report_mismatch("is_empty", want.is_empty, i_res.is_empty);
                    if (i_res.is_full !== want.is_full)
                        report_mismatch("is_full", want.is_full, i_res.is_full);
                    if (!want.ok) o_refused_seen++;
                    if (want.is_full) o_full_seen++;
                end
                o_results_seen++;
            end
        end
        o_pending = status_q.size();
    end

endmodule

// ===== tb/tb_circular_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque
// Stimulus and verdict for the circular deque. A short directed run hits the
// empty and full refusals, the value extremes and the out-of-range capacity
// settings; then phases at different capacities send random operations in
// grow and shrink bursts so the deque keeps reaching full and empty. Both
// handshake sides idle at random. Checking is done by cdq_checker.
// ----------------------------------------------------------------------------
module tb_circular_deque;
    import cdq_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RUN_LIMIT_NS    = 5_000_000;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int STALL_PHASE     = 1;
    localparam int PAUSE_PHASE     = 6;
    localparam int LONG_HOLD       = 120;
    localparam int MAX_IDLE        = 17;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cdq_op_if  op_ch ();
    cdq_res_if res_ch ();
    cdq_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int results_seen;
    int refused_seen;
    int full_seen;

    bit send_idle     = 1'b0;
    bit recv_idle     = 1'b0;
    bit recv_hold_req = 1'b0;

    // zero and anything above 16 exercise the clamping of the capacity
    logic [CAP_W-1:0] capacity_plan [N_PHASES] = '{
        5'd1, 5'd16, 5'd2, 5'd31, 5'd3, 5'd0, 5'd7, 5'd16, 5'd4, 5'd20, 5'd1, 5'd12
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    circular_deque dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    cdq_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_op           (op_ch),
        .i_res          (res_ch),
        .i_cfg          (cfg_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_refused_seen (refused_seen),
        .o_full_seen    (full_seen)
    );

    function automatic int draw_gap(bit enabled);
        return enabled ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    function automatic t_action pick_action(bit grow);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return t_action'($urandom_range(0, 3));
        if ((r <= 7) == grow) return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // called right after a falling edge with nothing driven in that step yet
    task automatic send_op(input t_action act, input logic [VAL_W-1:0] val);
        int gap;
        gap = draw_gap(send_idle);
        if (gap != 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op_ch.valid  <= 1'b1;
        op_ch.action <= act;
        op_ch.value  <= val;
        do @(posedge clk); while (!op_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        op_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: random hold-offs, one long one on request
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            gap = draw_gap(recv_idle);
            if (recv_hold_req) begin
                recv_hold_req = 1'b0;
                gap = LONG_HOLD;
            end
            @(negedge clk);
            if (gap != 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("ERROR: run did not finish in time, %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int  phase;
        int  n;
        int  burst_left;
        int  drain;
        bit  grow;

        op_ch.valid  = 1'b0;
        op_ch.action = ACT_PUSH_FRONT;
        op_ch.value  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset capacity, refusals on empty, value extremes at both ends
        send_op(ACT_POP_FRONT,  32'h1111_1111);
        send_op(ACT_POP_REAR,   32'h2222_2222);
        send_op(ACT_PUSH_FRONT, 32'h8000_0000);
        send_op(ACT_PUSH_REAR,  32'h7FFF_FFFF);
        send_op(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(ACT_PUSH_REAR,  32'h0000_0000);
        send_op(ACT_POP_FRONT,  '0);
        send_op(ACT_POP_REAR,   '0);
        send_op(ACT_POP_FRONT,  '0);
        send_op(ACT_POP_REAR,   '0);
        send_op(ACT_POP_REAR,   '0);
        wait_for_results();

        // single entry: full after one insert, a refused push at the front
        write_capacity(5'd1);
        send_op(ACT_PUSH_REAR,  32'h5A5A_5A5A);
        send_op(ACT_PUSH_FRONT, 32'hA5A5_A5A5);
        send_op(ACT_POP_FRONT,  '0);
        send_op(ACT_PUSH_FRONT, 32'h1234_5678);
        send_op(ACT_POP_REAR,   '0);
        wait_for_results();

        // capacity zero behaves as one entry
        write_capacity(5'd0);
        send_op(ACT_PUSH_FRONT, 32'hDEAD_BEEF);
        send_op(ACT_PUSH_REAR,  32'h0BAD_F00D);
        send_op(ACT_POP_FRONT,  '0);
        wait_for_results();

        // oversized capacity saturates to the ring depth
        write_capacity(5'd31);
        send_op(ACT_PUSH_REAR,  32'hC0DE_CAFE);
        send_op(ACT_POP_FRONT,  '0);
        wait_for_results();

        for (phase = 0; phase < N_PHASES; phase++) begin
            write_capacity(capacity_plan[phase]);
            send_idle  = ($urandom_range(0, 3) != 0);
            recv_idle  = ($urandom_range(0, 3) != 0);
            grow       = 1'b1;
            burst_left = $urandom_range(4, 40);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == STALL_PHASE && n == 10) recv_hold_req = 1'b1;
                if (phase == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) wait_for_results();
                if (burst_left == 0) begin
                    grow       = !grow;
                    burst_left = $urandom_range(4, 40);
                end
                burst_left--;
                send_op(pick_action(grow), pick_value());
            end
            wait_for_results();
        end

        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(negedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (pending != 0) $display("ERROR: %0d results never arrived", pending);
        $display("Checked %0d deque operations across %0d capacity settings, incl. 0 and >16",
                 results_seen, N_PHASES + 4);
        $display("  %0d refused on full/empty, %0d results reported the deque full",
                 refused_seen, full_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== circular_deque.f =====
src/cdq_pkg.sv
src/cdq_if.sv
src/cdq_ctrl.sv
src/cdq_dpath.sv
src/circular_deque.sv
tb/cdq_checker.sv
tb/tb_circular_deque.sv
